### rtl/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

	localparam int DEF_MAX_FRAMES  = 32768;
	localparam int DEF_FRAME_BYTES = 4096;

	localparam int ADDR_W   = 32;
	localparam int FADDR_W  = 27;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 16;

	localparam logic [COUNT_W-1:0] RESET_FRAME_COUNT = 16'd32768;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_FREE   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_WAS_FREE  = 2'd3;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] addr;
	} bfa_req_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  free_count;
		logic [STATUS_W-1:0] status;
		logic [FADDR_W-1:0]  frame_address;
	} bfa_result_t;

endpackage

### rtl/bitmap_frame_allocator_top.sv
// Top level of the bitmap frame allocator: stream ports, count register, result register.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser selects allocate (0) or free (1),
//   s_tdata carries the byte address to free. Every request gives one result
//   on the m_ stream: frame address, status and the free frame count after it.
//   cfg_we/cfg_wdata write the managed frame count and mark every frame free.
// Sequence:
//   A free passes from acceptance through the free check to the result register
//   (straight to it when the address is out of range). An allocate reads the
//   32-word summary entries in order until one with a non-full word turns up
//   (1 to MAX_FRAMES/1024 entries read) and then checks that map word. One
//   request is worked on at a time; the next is accepted as soon as the previous
//   result has left the engine.
// Reset and configuration:
//   After reset, and after every count write, a clearing pass walks the map,
//   one 32-frame word per cycle (MAX_FRAMES/32 words, 1024 by default), while
//   s_tready stays low.
// Stall:
//   A result waiting on m_tready holds the output register; the engine can
//   finish one more request behind it and then stops taking new ones.
module bitmap_frame_allocator_top #(
	parameter int MAX_FRAMES  = bfa_pkg::DEF_MAX_FRAMES,
	parameter int FRAME_BYTES = bfa_pkg::DEF_FRAME_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bfa_pkg::COUNT_W-1:0] cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // [31:0] free_address
	input  logic [0:0]                  s_tuser,   // [0] func
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [47:0]                 m_tdata    // [26:0] frame_address, [28:27] status,
	                                               // [44:29] free_count, [47:45] zero
);
	import bfa_pkg::*;

	logic [COUNT_W-1:0] frame_count_q;
	logic               m_valid_q;
	bfa_result_t        out_q;
	bfa_req_t           req;
	bfa_result_t        res;
	logic               res_valid;
	logic               res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame_count_q <= RESET_FRAME_COUNT;
		else if (cfg_we)
			frame_count_q <= cfg_wdata;
	end

	assign req.func = s_tuser[0];
	assign req.addr = s_tdata;

	bfa_engine #(
		.MAX_FRAMES  (MAX_FRAMES),
		.FRAME_BYTES (FRAME_BYTES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.frame_count (frame_count_q),
		.req_valid   (s_tvalid),
		.req_ready   (s_tready),
		.req         (req),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res)
	);

	assign res_take = res_valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			out_q     <= '0;
		end else if (res_take) begin
			m_valid_q <= 1'b1;
			out_q     <= res;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, out_q.free_count, out_q.status, out_q.frame_address};

endmodule

### rtl/bfa_engine.sv
// Allocation engine: frame map and full-word summary memories, search and update sequencer.
module bfa_engine #(
	parameter int MAX_FRAMES  = bfa_pkg::DEF_MAX_FRAMES,
	parameter int FRAME_BYTES = bfa_pkg::DEF_FRAME_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bfa_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic [bfa_pkg::COUNT_W-1:0]  frame_count,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  bfa_pkg::bfa_req_t            req,
	output logic                         res_valid,
	input  logic                         res_take,
	output bfa_pkg::bfa_result_t         res
);
	import bfa_pkg::*;

	localparam int WORDS     = (MAX_FRAMES + 31) / 32;
	localparam int SUM_WORDS = (WORDS + 31) / 32;
	localparam int WI_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SI_W      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
	localparam int SHIFT     = $clog2(FRAME_BYTES);
	localparam int LIM_W     = $clog2(MAX_FRAMES + 1);
	localparam int RST_LIM   = (int'(RESET_FRAME_COUNT) > MAX_FRAMES) ? MAX_FRAMES
	                                                                  : int'(RESET_FRAME_COUNT);
	localparam logic [SI_W-1:0] SUM_LAST = SI_W'(SUM_WORDS - 1);
	localparam logic [WI_W-1:0] WORD_LAST = WI_W'(WORDS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM_CHK,
		ST_MAP_CHK,
		ST_FREE_CHK,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [WI_W-1:0]    cnt_q;
	logic [SI_W-1:0]    sidx_q;
	logic [WI_W-1:0]    w_q;
	logic [4:0]         bpos_q;
	logic [31:0]        sword_q;
	logic [COUNT_W-1:0] free_total_q;
	bfa_result_t        res_q;

	logic [31:0] map_mem [WORDS];
	logic [31:0] sum_mem [SUM_WORDS];
	logic [31:0] map_rd_q;
	logic [31:0] sum_rd_q;

	logic            map_we;
	logic [WI_W-1:0] map_wa;
	logic [WI_W-1:0] map_ra;
	logic [31:0]     map_wd;
	logic            sum_we;
	logic [SI_W-1:0] sum_wa;
	logic [SI_W-1:0] sum_ra;
	logic [31:0]     sum_wd;

	logic [LIM_W-1:0]   lim;
	logic [COUNT_W-1:0] cfg_lim;
	logic [31:0]        fn32;
	logic [31:0]        wsel32;
	logic [31:0]        n32;
	logic [4:0]         spos;
	logic [4:0]         mpos;
	logic               sfound;
	logic               mfound;
	logic               alloc_ok;
	logic               free_ok;
	logic               free_range;
	logic [31:0]        mset;
	logic [31:0]        mclr;
	logic [31:0]        pad;

	assign lim = (32'(frame_count) > 32'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES)
	                                                   : LIM_W'(frame_count);
	assign cfg_lim = (32'(cfg_wdata) > 32'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : cfg_wdata;

	assign fn32       = req.addr >> SHIFT;
	assign free_range = fn32 >= 32'(lim);

	// lowest zero bit in the summary word and in the map word
	always_comb begin
		spos = '0;
		mpos = '0;
		for (int i = 31; i >= 0; i--) begin
			if (!sum_rd_q[i])
				spos = 5'(i);
			if (!map_rd_q[i])
				mpos = 5'(i);
		end
	end

	assign sfound   = ~&sum_rd_q;
	assign mfound   = ~&map_rd_q;
	assign wsel32   = (32'(sidx_q) << 5) | 32'(spos);
	assign n32      = (32'(w_q) << 5) | 32'(mpos);
	assign alloc_ok = mfound && (n32 < 32'(lim));
	assign free_ok  = map_rd_q[bpos_q];
	assign mset     = map_rd_q | (32'd1 << mpos);
	assign mclr     = map_rd_q & ~(32'd1 << bpos_q);

	// summary bits of words past the end of the map read as full
	always_comb begin
		for (int b = 0; b < 32; b++)
			pad[b] = (((32'(cnt_q) << 5) | 32'(b)) >= 32'(WORDS));
	end

	always_comb begin
		map_ra = w_q;
		sum_ra = sidx_q;
		unique case (state_q)
			ST_IDLE: begin
				map_ra = fn32[5 +: WI_W];
				sum_ra = (req.func == FUNC_FREE) ? fn32[10 +: SI_W] : '0;
			end
			ST_SUM_CHK: begin
				map_ra = wsel32[WI_W-1:0];
				sum_ra = (sidx_q == SUM_LAST) ? sidx_q : sidx_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		map_we = 1'b0;
		map_wa = w_q;
		map_wd = mclr;
		sum_we = 1'b0;
		sum_wa = sidx_q;
		// freed word is no longer full: clear its bit in the summary word
		sum_wd = sum_rd_q & ~(32'd1 << w_q[4:0]);
		unique case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
				map_wa = cnt_q;
				map_wd = '0;
				sum_we = 32'(cnt_q) < 32'(SUM_WORDS);
				sum_wa = cnt_q[SI_W-1:0];
				sum_wd = pad;
			end
			ST_MAP_CHK: begin
				map_we = alloc_ok;
				map_wd = mset;
				sum_we = alloc_ok && (&mset);
				sum_wd = sword_q | (32'd1 << bpos_q);
			end
			ST_FREE_CHK: begin
				map_we = free_ok;
				sum_we = free_ok;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we)
			map_mem[map_wa] <= map_wd;
		map_rd_q <= map_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (sum_we)
			sum_mem[sum_wa] <= sum_wd;
		sum_rd_q <= sum_mem[sum_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			free_total_q <= COUNT_W'(RST_LIM);
			sidx_q       <= '0;
			w_q          <= '0;
			bpos_q       <= '0;
			sword_q      <= '0;
			res_q        <= '0;
		end else if (cfg_we) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			free_total_q <= cfg_lim;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == WORD_LAST)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) begin
						res_q.frame_address <= '0;
						res_q.free_count    <= free_total_q;
						if (req.func == FUNC_ALLOC) begin
							sidx_q  <= '0;
							state_q <= ST_SUM_CHK;
						end else if (free_range) begin
							res_q.status <= STAT_RANGE;
							state_q      <= ST_DONE;
						end else begin
							w_q     <= fn32[5 +: WI_W];
							bpos_q  <= fn32[4:0];
							sidx_q  <= fn32[10 +: SI_W];
							state_q <= ST_FREE_CHK;
						end
					end
				end
				ST_SUM_CHK: begin
					if (sfound) begin
						w_q     <= wsel32[WI_W-1:0];
						bpos_q  <= spos;
						sword_q <= sum_rd_q;
						state_q <= ST_MAP_CHK;
					end else if (sidx_q == SUM_LAST) begin
						res_q.status <= STAT_NO_FREE;
						state_q      <= ST_DONE;
					end else begin
						sidx_q <= sidx_q + 1'b1;
					end
				end
				ST_MAP_CHK: begin
					// lowest free frame past the managed count means none is free
					if (alloc_ok) begin
						res_q.status        <= STAT_OK;
						res_q.frame_address <= FADDR_W'(n32 << SHIFT);
						if (free_total_q != '0) begin
							free_total_q     <= free_total_q - 1'b1;
							res_q.free_count <= free_total_q - 1'b1;
						end
					end else begin
						res_q.status <= STAT_NO_FREE;
					end
					state_q <= ST_DONE;
				end
				ST_FREE_CHK: begin
					if (free_ok) begin
						res_q.status     <= STAT_OK;
						free_total_q     <= free_total_q + 1'b1;
						res_q.free_count <= free_total_q + 1'b1;
					end else begin
						res_q.status <= STAT_WAS_FREE;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && !cfg_we) |=> !req_ready)
		else $error("engine took a second request while busy");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_take && !cfg_we) |=> (res_valid && $stable(res)))
		else $error("pending result changed before it was taken");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!req_ready && !res_valid && map_we))
		else $error("clearing pass overlapped request handling");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && cnt_q == WORD_LAST && !cfg_we) |=> (state_q == ST_IDLE))
		else $error("clearing pass did not end at the last map word");

	a_map_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		map_we |-> (32'(map_wa) < 32'(WORDS)))
		else $error("map write beyond the last word");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap frame allocator: directed table, random phases.
module tb_top;
	import bfa_pkg::*;

	localparam int MAX_FRAMES  = DEF_MAX_FRAMES;
	localparam int FRAME_BYTES = DEF_FRAME_BYTES;
	localparam int MAP_WORDS   = (MAX_FRAMES + 31) / 32;
	localparam int IDLE_LIMIT  = 4000;
	localparam int LONG_HOLD   = 400;

	typedef struct {
		bit                 is_cfg;
		logic [COUNT_W-1:0] cfg_val;
		logic               func;
		logic [ADDR_W-1:0]  addr;
		bit                 typed;
		bfa_result_t        res;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [COUNT_W-1:0]  cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [31:0]         s_tdata;
	logic [0:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [47:0]         m_tdata;

	// allocator model state
	logic [31:0]         used_words [0:MAP_WORDS-1];
	logic [COUNT_W-1:0]  frame_count_reg;
	logic [COUNT_W-1:0]  model_free;

	bfa_result_t         pending_results [$];
	dir_row_t            dir_rows [$];
	int                  fail_count = 0;
	int                  idle_cycles = 0;
	int                  stall_left = 0;
	bit                  long_hold_req = 1'b0;
	bit                  quiet = 1'b0;

	bitmap_frame_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic int managed_frames();
		return (frame_count_reg > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count_reg);
	endfunction

	function automatic void load_frame_count(logic [COUNT_W-1:0] v);
		frame_count_reg = v;
		for (int w = 0; w < MAP_WORDS; w++)
			used_words[w] = '0;
		model_free = COUNT_W'(managed_frames());
	endfunction

	function automatic bfa_result_t apply_request(logic func, logic [ADDR_W-1:0] addr);
		bfa_result_t r;
		int lim;
		int n;
		logic [31:0] fn;
		bit found;
		lim = managed_frames();
		r = '0;
		found = 1'b0;
		if (func == FUNC_ALLOC) begin
			n = 0;
			while (!found && n < lim) begin
				if (used_words[n >> 5] == 32'hFFFF_FFFF)
					n = (n | 31) + 1;	// whole word taken, skip it
				else if (used_words[n >> 5][n & 31])
					n++;
				else
					found = 1'b1;
			end
			if (found) begin
				used_words[n >> 5][n & 31] = 1'b1;
				if (model_free != 0)
					model_free--;
				r.frame_address = FADDR_W'(n * FRAME_BYTES);
			end else begin
				r.status = STAT_NO_FREE;
			end
		end else begin
			fn = addr / FRAME_BYTES;
			if (fn >= lim) begin
				r.status = STAT_RANGE;
			end else if (!used_words[fn >> 5][fn[4:0]]) begin
				r.status = STAT_WAS_FREE;
			end else begin
				used_words[fn >> 5][fn[4:0]] = 1'b0;
				model_free++;
			end
		end
		r.free_count = model_free;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(12, 60);
	endfunction

	function automatic void add_cfg(logic [COUNT_W-1:0] v);
		dir_row_t row;
		row.is_cfg = 1'b1;
		row.cfg_val = v;
		row.func = FUNC_ALLOC;
		row.addr = '0;
		row.typed = 1'b0;
		row.res = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_req(logic func, logic [ADDR_W-1:0] addr, bit typed,
			logic [FADDR_W-1:0] fa, logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.cfg_val = '0;
		row.func = func;
		row.addr = addr;
		row.typed = typed;
		row.res.frame_address = fa;
		row.res.status = st;
		row.res.free_count = cnt;
		dir_rows.push_back(row);
	endfunction

	task automatic send_req(logic func, logic [ADDR_W-1:0] addr, bit typed,
			bfa_result_t typed_res);
		bfa_result_t res;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= addr;
		do @(posedge clk); while (!s_tready);
		res = apply_request(func, addr);
		pending_results.push_back(typed ? typed_res : res);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// only written with nothing in flight; every request yields a result
	task automatic write_frame_count(logic [COUNT_W-1:0] v);
		wait_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		load_frame_count(v);
		cfg_we <= 1'b0;
	endtask

	task automatic check_result(logic [47:0] data);
		bfa_result_t got;
		bfa_result_t want;
		got = data[44:0];
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result: addr %h status %0d count %0d",
					got.frame_address, got.status, got.free_count);
		end else begin
			want = pending_results.pop_front();
			if (got.frame_address !== want.frame_address || got.status !== want.status ||
					got.free_count !== want.free_count) begin
				fail_count++;
				if (fail_count <= 10)
					$display("mismatch: exp addr %h status %0d count %0d, got addr %h status %0d count %0d",
						want.frame_address, want.status, want.free_count,
						got.frame_address, got.status, got.free_count);
			end
		end
	endtask

	// result side: random stalls, plus one long hold on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		bfa_result_t none;
		logic [COUNT_W-1:0] fc;
		logic func;
		logic [ADDR_W-1:0] addr;
		int lim;
		int cap;
		int alloc_pct;
		none = '0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FUNC_ALLOC;
		m_tready  <= 1'b0;
		load_frame_count(RESET_FRAME_COUNT);

		// default size after reset
		add_req(FUNC_ALLOC, 32'h0000_0000, 1'b1, 27'h0000000, STAT_OK, 16'd32767);
		add_req(FUNC_ALLOC, 32'h0000_0000, 1'b1, 27'h0001000, STAT_OK, 16'd32766);
		add_req(FUNC_FREE,  32'hFFFF_FFFF, 1'b1, 27'h0000000, STAT_RANGE, 16'd32766);
		add_req(FUNC_FREE,  32'h0000_1FFF, 1'b1, 27'h0000000, STAT_OK, 16'd32767);
		add_req(FUNC_FREE,  32'h0000_1000, 1'b1, 27'h0000000, STAT_WAS_FREE, 16'd32767);
		add_req(FUNC_FREE,  32'h07FF_F000, 1'b1, 27'h0000000, STAT_WAS_FREE, 16'd32767);
		add_req(FUNC_FREE,  32'h0800_0000, 1'b1, 27'h0000000, STAT_RANGE, 16'd32767);
		add_req(FUNC_ALLOC, 32'h0000_0000, 1'b1, 27'h0001000, STAT_OK, 16'd32766);
		// single frame: full after one allocate
		add_cfg(16'd1);
		add_req(FUNC_ALLOC, 32'h0000_0000, 1'b1, 27'h0000000, STAT_OK, 16'd0);
		add_req(FUNC_ALLOC, 32'hFFFF_FFFF, 1'b1, 27'h0000000, STAT_NO_FREE, 16'd0);
		add_req(FUNC_FREE,  32'h0000_1000, 1'b1, 27'h0000000, STAT_RANGE, 16'd0);
		add_req(FUNC_FREE,  32'h0000_0ABC, 1'b1, 27'h0000000, STAT_OK, 16'd1);
		add_req(FUNC_FREE,  32'h0000_0000, 1'b1, 27'h0000000, STAT_WAS_FREE, 16'd1);
		// nothing managed
		add_cfg(16'd0);
		add_req(FUNC_ALLOC, 32'h0000_0000, 1'b1, 27'h0000000, STAT_NO_FREE, 16'd0);
		add_req(FUNC_FREE,  32'h0000_0000, 1'b1, 27'h0000000, STAT_RANGE, 16'd0);
		// count above capacity clamps
		add_cfg(16'hFFFF);
		add_req(FUNC_ALLOC, 32'h0000_0000, 1'b1, 27'h0000000, STAT_OK, 16'd32767);
		add_req(FUNC_ALLOC, 32'h0000_0000, 1'b0, '0, STAT_OK, '0);
		add_req(FUNC_FREE,  32'hAAAA_A555, 1'b0, '0, STAT_OK, '0);
		add_req(FUNC_FREE,  32'h5555_5AAA, 1'b0, '0, STAT_OK, '0);
		add_req(FUNC_FREE,  32'h0000_1234, 1'b0, '0, STAT_OK, '0);
		add_cfg(16'd40);
		add_req(FUNC_ALLOC, 32'h0000_0000, 1'b0, '0, STAT_OK, '0);
		add_req(FUNC_FREE,  32'h0000_0FFF, 1'b0, '0, STAT_OK, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_frame_count(dir_rows[i].cfg_val);
			else
				send_req(dir_rows[i].func, dir_rows[i].addr, dir_rows[i].typed,
					dir_rows[i].res);
		end

		for (int p = 0; p < 12; p++) begin
			case (p % 6)
				0: fc = COUNT_W'($urandom_range(1, 8));
				1: fc = COUNT_W'($urandom_range(9, 70));
				2: fc = 16'd32;
				3: fc = 16'd32768;
				4: fc = COUNT_W'($urandom_range(32769, 65535));
				default: fc = COUNT_W'($urandom_range(1, 40));
			endcase
			write_frame_count(fc);
			quiet = (p == 3) || (p == 8);
			for (int k = 0; k < 48; k++) begin
				// back-pressure: results held while requests keep coming
				if (p == 3 && k == 1)
					long_hold_req = 1'b1;
				if (p == 5 && k == 24)
					wait_results();
				alloc_pct = (k < 28) ? 75 : 30;	// fill, then drain
				lim = managed_frames();
				if ($urandom_range(0, 99) < alloc_pct) begin
					func = FUNC_ALLOC;
					addr = $urandom;
				end else begin
					func = FUNC_FREE;
					if ($urandom_range(0, 99) < 80) begin
						cap = (lim > 64) ? 64 : lim;
						addr = ($urandom_range(0, cap) * FRAME_BYTES) |
							$urandom_range(0, FRAME_BYTES - 1);
					end else begin
						addr = $urandom;
					end
				end
				send_req(func, addr, 1'b0, none);
			end
		end

		quiet = 1'b0;
		wait_results();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
